FILE: src/lms_pkg.sv
// Shared types, codes and constants for the lock motor sequencer.
package lms_pkg;

	localparam int TIME_BITS = 16;
	localparam int CFG_W     = 16;
	localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	localparam logic [CFG_W-1:0] RELOCK_DELAY_RST   = CFG_W'(3000);
	localparam logic [CFG_W-1:0] MOTION_TIMEOUT_RST = CFG_W'(5000);

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_UNLOCK = 2'd1,
		KIND_RELOCK = 2'd2,
		KIND_STOP   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE      = 2'd0,
		MODE_UNLOCKING = 2'd1,
		MODE_WAIT      = 2'd2,
		MODE_RELOCKING = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_STARTED = 3'd1,
		EV_BUSY    = 3'd2,
		EV_PRECOND = 3'd3,
		EV_LIMIT   = 3'd4,
		EV_TIMEOUT = 3'd5,
		EV_STOPPED = 3'd6
	} event_t;

	typedef enum logic {
		REG_RELOCK_DELAY   = 1'b0,
		REG_MOTION_TIMEOUT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] relock_delay;
		logic [CFG_W-1:0] motion_timeout;
	} cfg_t;

endpackage

FILE: src/lms_if.sv
// Request and result channel interfaces of the lock motor sequencer.
interface lms_cmd_if import lms_pkg::*; ();
	logic  valid;
	logic  ready;
	kind_t kind;
	logic  open_limit;
	logic  close_limit;
	logic  door_closed;

	modport source (output valid, kind, open_limit, close_limit, door_closed, input ready);
	modport sink (input valid, kind, open_limit, close_limit, door_closed, output ready);
endinterface

interface lms_res_if import lms_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   open_drive;
	logic   reset_drive;
	mode_t  mode;
	event_t event_res;

	modport source (output valid, open_drive, reset_drive, mode, event_res, input ready);
	modport sink (input valid, open_drive, reset_drive, mode, event_res, output ready);
endinterface

FILE: src/lms_apb_regs.sv
// APB configuration registers: relock delay and motion timeout.
module lms_apb_regs import lms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	// word aligned: byte lane bits are ignored
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.relock_delay   <= RELOCK_DELAY_RST;
			cfg_q.motion_timeout <= MOTION_TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_RELOCK_DELAY:   cfg_q.relock_delay   <= pwdata[CFG_W-1:0];
				REG_MOTION_TIMEOUT: cfg_q.motion_timeout <= pwdata[CFG_W-1:0];
				default:            ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RELOCK_DELAY:   prdata = PDATA_W'(cfg_q.relock_delay);
			REG_MOTION_TIMEOUT: prdata = PDATA_W'(cfg_q.motion_timeout);
			default:            prdata = '0;
		endcase
	end

endmodule

FILE: src/lock_motor_sequencer.sv
// Lock motor sequencer: the result register loads on each accepted request.
// One request per cycle unless a result stalls; the mode and tick counter update
// in a single combinational pass between the state registers and the result register.
// The result register frees itself when taken, so a stalled result only holds
// off new requests while the sink keeps ready low.
// Asynchronous reset: mode idle, drives low, counter zero, registers to defaults.
module lock_motor_sequencer import lms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	lms_cmd_if.sink            cmd,
	lms_res_if.source          res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t cfg;

	lms_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mode_t                mode_q, mode_n;
	logic [TIME_BITS-1:0] elapsed_q, elapsed_n, elapsed_inc;
	logic                 open_drive_q, open_drive_n;
	logic                 reset_drive_q, reset_drive_n;
	event_t               ev_n;

	logic   res_valid_q;
	logic   res_open_q, res_reset_q;
	mode_t  res_mode_q;
	event_t res_event_q;

	logic accept;
	logic at_limit;
	logic timed_out;
	logic wait_done;

	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	// saturate the tick count
	assign elapsed_inc = (elapsed_q != TIME_MAX) ? elapsed_q + 1'b1 : elapsed_q;
	assign at_limit    = (mode_q == MODE_UNLOCKING) ? cmd.open_limit : cmd.close_limit;
	assign timed_out   = CMP_W'(elapsed_inc) > CMP_W'(cfg.motion_timeout);
	assign wait_done   = (CMP_W'(elapsed_inc) >= CMP_W'(cfg.relock_delay)) || cmd.door_closed;

	always_comb begin
		mode_n        = mode_q;
		elapsed_n     = elapsed_q;
		open_drive_n  = open_drive_q;
		reset_drive_n = reset_drive_q;
		ev_n          = EV_NONE;
		unique case (cmd.kind)
			KIND_TICK: begin
				unique case (mode_q)
					MODE_UNLOCKING, MODE_RELOCKING: begin
						// limit wins over timeout
						if (at_limit || timed_out) begin
							mode_n        = MODE_IDLE;
							elapsed_n     = '0;
							open_drive_n  = 1'b0;
							reset_drive_n = 1'b0;
							ev_n          = at_limit ? EV_LIMIT : EV_TIMEOUT;
						end else begin
							elapsed_n = elapsed_inc;
						end
					end
					MODE_WAIT: begin
						if (wait_done) begin
							mode_n        = MODE_RELOCKING;
							elapsed_n     = '0;
							open_drive_n  = 1'b0;
							reset_drive_n = 1'b1;
							ev_n          = EV_STARTED;
						end else begin
							elapsed_n = elapsed_inc;
						end
					end
					default: ;
				endcase
			end
			KIND_UNLOCK: begin
				if (mode_q != MODE_IDLE) begin
					ev_n = EV_BUSY;
				end else if (!cmd.close_limit) begin
					ev_n = EV_PRECOND;
				end else begin
					mode_n        = MODE_UNLOCKING;
					elapsed_n     = '0;
					open_drive_n  = 1'b1;
					reset_drive_n = 1'b0;
					ev_n          = EV_STARTED;
				end
			end
			KIND_RELOCK: begin
				if (mode_q != MODE_IDLE) begin
					ev_n = EV_BUSY;
				end else if (!cmd.open_limit) begin
					ev_n = EV_PRECOND;
				end else begin
					mode_n    = MODE_WAIT;
					elapsed_n = '0;
					ev_n      = EV_STARTED;
				end
			end
			default: begin
				mode_n        = MODE_IDLE;
				elapsed_n     = '0;
				open_drive_n  = 1'b0;
				reset_drive_n = 1'b0;
				ev_n          = EV_STOPPED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			elapsed_q     <= '0;
			open_drive_q  <= 1'b0;
			reset_drive_q <= 1'b0;
		end else if (accept) begin
			mode_q        <= mode_n;
			elapsed_q     <= elapsed_n;
			open_drive_q  <= open_drive_n;
			reset_drive_q <= reset_drive_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_open_q  <= open_drive_n;
			res_reset_q <= reset_drive_n;
			res_mode_q  <= mode_n;
			res_event_q <= ev_n;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.open_drive  = res_open_q;
	assign res.reset_drive = res_reset_q;
	assign res.mode        = res_mode_q;
	assign res.event_res   = res_event_q;

	a_drives_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(open_drive_q && reset_drive_q))
		else $error("both motor drives high");

	a_drive_matches_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(open_drive_q == (mode_q == MODE_UNLOCKING)) &&
		(reset_drive_q == (mode_q == MODE_RELOCKING)))
		else $error("drive levels disagree with mode");

	a_idle_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (elapsed_q == '0))
		else $error("tick count not cleared while idle");

	a_stop_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.kind == KIND_STOP) |=>
		(mode_q == MODE_IDLE && res.event_res == EV_STOPPED && res.valid))
		else $error("stop request did not halt the motor");

endmodule

FILE: dv/lock_motor_sequencer_tb.sv
// Self-checking testbench for the lock motor sequencer: every status result is checked against a predicted one.
module lock_motor_sequencer_tb import lms_pkg::*; ();

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int REPORT_CAP  = 100;

	typedef struct packed {
		logic   open_drive;
		logic   reset_drive;
		mode_t  mode;
		event_t ev;
	} status_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	lms_cmd_if cmd_ch ();
	lms_res_if res_ch ();

	lock_motor_sequencer uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predicted lock state and timing registers
	mode_t                lock_mode;
	logic [TIME_BITS-1:0] lock_elapsed;
	logic                 open_q;
	logic                 reset_q;
	logic [CFG_W-1:0]     relock_delay_q;
	logic [CFG_W-1:0]     motion_timeout_q;

	status_t     pending_status[$];
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned status_count;
	int unsigned gap_pct;
	int unsigned stall_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		error_count++;
		if (error_count <= REPORT_CAP)
			$display("mismatch at status %0d: %s got %0h want %0h", status_count, what, got, want);
	endtask

	task automatic halt_lock();
		open_q       = 1'b0;
		reset_q      = 1'b0;
		lock_mode    = MODE_IDLE;
		lock_elapsed = '0;
	endtask

	task automatic advance_lock_model(kind_t k, logic ol, logic cl, logic dc,
			output status_t st);
		event_t ev;
		logic   at_limit;
		ev = EV_NONE;
		case (k)
			KIND_TICK: begin
				if (lock_mode != MODE_IDLE && lock_elapsed != TIME_MAX)
					lock_elapsed++;
				if (lock_mode == MODE_UNLOCKING || lock_mode == MODE_RELOCKING) begin
					at_limit = (lock_mode == MODE_UNLOCKING) ? ol : cl;
					// limit takes priority over timeout
					if (at_limit) begin
						halt_lock();
						ev = EV_LIMIT;
					end else if (lock_elapsed > motion_timeout_q) begin
						halt_lock();
						ev = EV_TIMEOUT;
					end
				end else if (lock_mode == MODE_WAIT) begin
					if (lock_elapsed >= relock_delay_q || dc) begin
						lock_mode    = MODE_RELOCKING;
						lock_elapsed = '0;
						open_q       = 1'b0;
						reset_q      = 1'b1;
						ev           = EV_STARTED;
					end
				end
			end
			KIND_UNLOCK: begin
				if (lock_mode != MODE_IDLE) begin
					ev = EV_BUSY;
				end else if (!cl) begin
					ev = EV_PRECOND;
				end else begin
					lock_mode    = MODE_UNLOCKING;
					lock_elapsed = '0;
					reset_q      = 1'b0;
					open_q       = 1'b1;
					ev           = EV_STARTED;
				end
			end
			KIND_RELOCK: begin
				if (lock_mode != MODE_IDLE) begin
					ev = EV_BUSY;
				end else if (!ol) begin
					ev = EV_PRECOND;
				end else begin
					lock_mode    = MODE_WAIT;
					lock_elapsed = '0;
					ev           = EV_STARTED;
				end
			end
			default: begin
				halt_lock();
				ev = EV_STOPPED;
			end
		endcase
		st.open_drive  = open_q;
		st.reset_drive = reset_q;
		st.mode        = lock_mode;
		st.ev          = ev;
	endtask

	// Predict on each accepted request, check each accepted result against the oldest prediction
	always @(posedge clk) begin
		status_t want;
		status_t got;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				advance_lock_model(cmd_ch.kind, cmd_ch.open_limit, cmd_ch.close_limit,
					cmd_ch.door_closed, want);
				pending_status.push_back(want);
			end
			if (res_ch.valid && res_ch.ready) begin
				got.open_drive  = res_ch.open_drive;
				got.reset_drive = res_ch.reset_drive;
				got.mode        = res_ch.mode;
				got.ev          = res_ch.event_res;
				if (pending_status.size() == 0) begin
					report("status with nothing pending", got, 0);
				end else begin
					want = pending_status.pop_front();
					if (got.open_drive !== want.open_drive)
						report("open_drive", got.open_drive, want.open_drive);
					if (got.reset_drive !== want.reset_drive)
						report("reset_drive", got.reset_drive, want.reset_drive);
					if (got.mode !== want.mode)
						report("mode", got.mode, want.mode);
					if (got.ev !== want.ev)
						report("event_res", got.ev, want.ev);
				end
				status_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("lock_motor_sequencer_tb: errors");
			$finish;
		end
	end

	always @(negedge clk)
		res_ch.ready = ($urandom_range(99) >= stall_pct);

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(kind_t k, logic ol, logic cl, logic dc);
		while ($urandom_range(99) < gap_pct) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid       = 1'b1;
		cmd_ch.kind        = k;
		cmd_ch.open_limit  = ol;
		cmd_ch.close_limit = cl;
		cmd_ch.door_closed = dc;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_status();
		cmd_ch.valid = 1'b0;
		while (pending_status.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Write a timing register, then read it back
	task automatic write_register(reg_idx_t idx, logic [CFG_W-1:0] value);
		logic [PDATA_W-1:0] word;
		word            = $urandom;
		word[CFG_W-1:0] = value;
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = PADDR_W'({idx, 2'b00});
		pwdata  = word;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_RELOCK_DELAY)
			relock_delay_q = value;
		else
			motion_timeout_q = value;
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		pwdata  = '0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[CFG_W-1:0] !== value)
			report("register readback", prdata, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic program_timing(logic [CFG_W-1:0] delay, logic [CFG_W-1:0] timeout);
		drain_status();
		write_register(REG_RELOCK_DELAY, delay);
		write_register(REG_MOTION_TIMEOUT, timeout);
	endtask

	// Rejections, stop in idle, unlock and relock runs under the reset timing
	task automatic test_command_basics();
		send_request(KIND_TICK, 1'b0, 1'b0, 1'b0);
		send_request(KIND_UNLOCK, 1'b1, 1'b0, 1'b1);
		send_request(KIND_RELOCK, 1'b0, 1'b1, 1'b0);
		send_request(KIND_STOP, 1'b1, 1'b1, 1'b1);
		send_request(KIND_UNLOCK, 1'b0, 1'b1, 1'b0);
		send_request(KIND_UNLOCK, 1'b0, 1'b1, 1'b0);
		send_request(KIND_RELOCK, 1'b1, 1'b0, 1'b0);
		send_request(KIND_TICK, 1'b0, 1'b1, 1'b1);
		send_request(KIND_TICK, 1'b1, 1'b0, 1'b0);
		send_request(KIND_RELOCK, 1'b1, 1'b0, 1'b0);
		send_request(KIND_TICK, 1'b1, 1'b0, 1'b0);
		send_request(KIND_TICK, 1'b1, 1'b0, 1'b1);
		send_request(KIND_UNLOCK, 1'b0, 1'b1, 1'b0);
		send_request(KIND_TICK, 1'b1, 1'b1, 1'b0);
	endtask

	// Zero delay and timeout: limit against timeout, immediate relock, stop in every busy mode
	task automatic test_limit_timeout_overlap();
		program_timing('0, '0);
		send_request(KIND_UNLOCK, 1'b0, 1'b1, 1'b0);
		send_request(KIND_TICK, 1'b1, 1'b0, 1'b0);
		send_request(KIND_UNLOCK, 1'b0, 1'b1, 1'b0);
		send_request(KIND_TICK, 1'b0, 1'b1, 1'b1);
		send_request(KIND_RELOCK, 1'b1, 1'b0, 1'b0);
		send_request(KIND_TICK, 1'b0, 1'b0, 1'b0);
		send_request(KIND_TICK, 1'b0, 1'b1, 1'b0);
		send_request(KIND_RELOCK, 1'b1, 1'b0, 1'b0);
		send_request(KIND_TICK, 1'b0, 1'b0, 1'b1);
		send_request(KIND_STOP, 1'b0, 1'b0, 1'b0);
		send_request(KIND_RELOCK, 1'b1, 1'b1, 1'b0);
		send_request(KIND_STOP, 1'b1, 1'b0, 1'b1);
		send_request(KIND_UNLOCK, 1'b1, 1'b1, 1'b1);
		send_request(KIND_STOP, 1'b0, 1'b1, 1'b0);
	endtask

	// Run a long unlock under the widest timeout, then lower the timeout so the held count trips it
	task automatic test_long_run();
		program_timing('1, '1);
		send_request(KIND_UNLOCK, 1'b0, 1'b1, 1'b0);
		repeat (60)
			send_request(KIND_TICK, 1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
		drain_status();
		write_register(REG_MOTION_TIMEOUT, CFG_W'(40));
		send_request(KIND_TICK, 1'b0, 1'b0, 1'b0);
		send_request(KIND_STOP, 1'b0, 1'b0, 1'b0);
	endtask

	// Mostly well-formed unlock and relock runs, steered by the predicted mode
	task automatic test_random_traffic(int unsigned count);
		kind_t       k;
		logic        ol;
		logic        cl;
		logic        dc;
		int unsigned pick;
		repeat (count) begin
			pick = $urandom_range(99);
			ol   = 1'($urandom_range(1));
			cl   = 1'($urandom_range(1));
			dc   = ($urandom_range(3) == 0);
			case (lock_mode)
				MODE_IDLE: begin
					if (pick < 42) begin
						k  = KIND_UNLOCK;
						cl = ($urandom_range(9) != 0);
					end else if (pick < 84) begin
						k  = KIND_RELOCK;
						ol = ($urandom_range(9) != 0);
					end else if (pick < 92) begin
						k = KIND_STOP;
					end else begin
						k = KIND_TICK;
					end
				end
				MODE_WAIT: begin
					dc = ($urandom_range(19) == 0);
					if (pick < 90)
						k = KIND_TICK;
					else if (pick < 95)
						k = $urandom_range(1) ? KIND_UNLOCK : KIND_RELOCK;
					else
						k = KIND_STOP;
				end
				default: begin
					// hold the limit of the current direction low most of the time
					if (lock_mode == MODE_UNLOCKING)
						ol = ($urandom_range(15) == 0);
					else
						cl = ($urandom_range(15) == 0);
					if (pick < 90)
						k = KIND_TICK;
					else if (pick < 96)
						k = $urandom_range(1) ? KIND_UNLOCK : KIND_RELOCK;
					else
						k = KIND_STOP;
				end
			endcase
			send_request(k, ol, cl, dc);
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.kind        = KIND_TICK;
		cmd_ch.open_limit  = 1'b0;
		cmd_ch.close_limit = 1'b0;
		cmd_ch.door_closed = 1'b0;
		res_ch.ready       = 1'b0;
		gap_pct            = 0;
		stall_pct          = 0;
		error_count        = 0;
		cycle_count        = 0;
		status_count       = 0;
		halt_lock();
		relock_delay_q     = RELOCK_DELAY_RST;
		motion_timeout_q   = MOTION_TIMEOUT_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_command_basics();
		test_limit_timeout_overlap();
		test_long_run();

		program_timing(CFG_W'(7), CFG_W'(12));
		test_random_traffic(200);

		program_timing(CFG_W'($urandom_range(40, 1)), CFG_W'($urandom_range(40, 1)));
		gap_pct = 51;
		test_random_traffic(200);

		program_timing('1, '0);
		gap_pct   = 0;
		stall_pct = 51;
		test_random_traffic(200);

		program_timing(CFG_W'($urandom_range(20)), CFG_W'($urandom_range(20)));
		gap_pct   = 38;
		stall_pct = 38;
		test_random_traffic(200);

		drain_status();
		if (error_count == 0)
			$display("lock_motor_sequencer_tb: clean");
		else
			$display("lock_motor_sequencer_tb: errors");
		$finish;
	end

endmodule

FILE: files.f
src/lms_pkg.sv
src/lms_if.sv
src/lms_apb_regs.sv
src/lock_motor_sequencer.sv
dv/lock_motor_sequencer_tb.sv
